@@ design/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg: shared codes for the i2c register access master
// Bus phase codes, byte stage codes, command codes and register map.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int PHASE_W = 4;
	localparam int STAGE_W = 2;

	// bus phases
	localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_START_HI = 4'd1;
	localparam logic [PHASE_W-1:0] PH_START_LO = 4'd2;
	localparam logic [PHASE_W-1:0] PH_SEND_LO  = 4'd3;
	localparam logic [PHASE_W-1:0] PH_SEND_HI  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ACK_LO   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_ACK_HI   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_RECV_LO  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_RECV_HI  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_MACK_LO  = 4'd9;
	localparam logic [PHASE_W-1:0] PH_MACK_HI  = 4'd10;
	localparam logic [PHASE_W-1:0] PH_STOP_LO  = 4'd11;
	localparam logic [PHASE_W-1:0] PH_STOP_HI  = 4'd12;
	localparam logic [PHASE_W-1:0] PH_STOP_REL = 4'd13;

	// which byte of the transfer is on the wire
	localparam logic [STAGE_W-1:0] STAGE_ADDR_W = 2'd0;
	localparam logic [STAGE_W-1:0] STAGE_REG    = 2'd1;
	localparam logic [STAGE_W-1:0] STAGE_DATA   = 2'd2;
	localparam logic [STAGE_W-1:0] STAGE_ADDR_R = 2'd3;

	// commands
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// register map
	localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
	localparam logic [1:0] REG_ACK_TMO   = 2'd1;
	localparam logic [1:0] REG_HOLD      = 2'd2;
	localparam logic [1:0] REG_HALF_BIT  = 2'd3;

	localparam logic [6:0] DEV_ADDR_RST = 7'd24;
	localparam logic [7:0] ACK_TMO_RST  = 8'd250;
	localparam logic [7:0] HOLD_RST     = 8'd4;
	localparam logic [7:0] HALF_BIT_RST = 8'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

@@ design/i2c_master_register_access_top.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// I2C master performing register writes and multi-byte register reads,
// advanced by one timing tick per input beat.
// ----------------------------------------------------------------------------
// Each input beat is either a timing tick or, while idle, a write or read
// command; it produces exactly one result beat with the SCL/SDA drives after
// that tick and the read, done and error flags. The
// bus sequencer state and the result register both update on the accepting
// edge, so a new beat is taken every cycle while the result register is
// empty or being drained. Bus timing is set entirely by the hold, half-bit
// and acknowledge timeout registers, counted in beats, not in clock cycles.
// A missing acknowledge aborts with a stop and raises ack_error with done.
module i2c_master_register_access_top
	import i2cm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] reg_address,
	input  logic [7:0] write_data,
	input  logic [7:0] read_count,
	input  logic       sda_in,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic [7:0] read_data,
	output logic       read_valid,
	output logic       last_byte,
	output logic       done_res,
	output logic       ack_error,
	output logic       busy_res
);

	// configuration registers
	logic [6:0] dev_addr_q;
	logic [7:0] ack_tmo_q;
	logic [7:0] hold_q;
	logic [7:0] half_q;

	// sequencer state
	logic [PHASE_W-1:0] phase_q;
	logic [7:0]         tick_q;
	logic [7:0]         shift_q;
	logic [3:0]         bit_q;
	logic [7:0]         left_q;
	logic               is_read_q;
	logic [7:0]         reg_addr_q;
	logic [7:0]         wr_data_q;
	logic               scl_q;
	logic               sda_q;
	logic               err_q;
	logic [STAGE_W-1:0] stage_q;

	logic [PHASE_W-1:0] n_phase;
	logic [7:0]         n_tick;
	logic [7:0]         n_shift;
	logic [3:0]         n_bit;
	logic [7:0]         n_left;
	logic               n_is_read;
	logic [7:0]         n_reg_addr;
	logic [7:0]         n_wr_data;
	logic               n_scl;
	logic               n_sda;
	logic               n_err;
	logic [STAGE_W-1:0] n_stage;

	logic [7:0] r_data;
	logic       r_valid;
	logic       r_last;
	logic       r_done;
	logic       r_err;

	// result register
	logic       out_valid_q;
	logic       scl_out_q;
	logic       sda_out_q;
	logic [7:0] rd_out_q;
	logic       rv_out_q;
	logic       lb_out_q;
	logic       dn_out_q;
	logic       ae_out_q;
	logic       busy_out_q;

	logic       accept;
	logic [7:0] half_dur;
	logic [7:0] hold_dur;
	logic [7:0] dur;
	logic [7:0] tick_inc;
	logic [3:0] bit_inc;
	logic [7:0] recv_byte;

	function automatic logic [7:0] stage_byte(input logic [STAGE_W-1:0] stage,
			input logic [6:0] dev, input logic [7:0] ra, input logic [7:0] wd);
		logic [7:0] b;
		case (stage)
			STAGE_ADDR_W: b = {dev, 1'b0};
			STAGE_REG:    b = ra;
			STAGE_DATA:   b = wd;
			default:      b = {dev, 1'b1};
		endcase
		return b;
	endfunction

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign half_dur  = (half_q == 8'd0) ? 8'd1 : half_q;
	assign hold_dur  = (hold_q == 8'd0) ? 8'd1 : hold_q;
	assign dur       = (phase_q inside {PH_START_HI, PH_START_LO, PH_STOP_HI, PH_STOP_REL})
		? hold_dur : half_dur;
	assign tick_inc  = tick_q + 8'd1;
	assign bit_inc   = bit_q + 4'd1;
	assign recv_byte = {shift_q[6:0], sda_in};

	always_comb begin
		logic [7:0] sb;
		n_phase    = phase_q;
		n_tick     = tick_q;
		n_shift    = shift_q;
		n_bit      = bit_q;
		n_left     = left_q;
		n_is_read  = is_read_q;
		n_reg_addr = reg_addr_q;
		n_wr_data  = wr_data_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_err      = err_q;
		n_stage    = stage_q;
		r_data     = 8'd0;
		r_valid    = 1'b0;
		r_last     = 1'b0;
		r_done     = 1'b0;
		r_err      = 1'b0;
		sb         = 8'd0;

		if (phase_q == PH_IDLE) begin
			if (action == ACT_WRITE || action == ACT_READ) begin
				n_is_read  = (action == ACT_READ);
				n_reg_addr = reg_address;
				n_wr_data  = write_data;
				n_left     = (read_count == 8'd0) ? 8'd1 : read_count;
				n_err      = 1'b0;
				n_stage    = STAGE_ADDR_W;
				n_phase    = PH_START_HI;
				n_tick     = 8'd0;
				n_scl      = 1'b1;
				n_sda      = 1'b1;
			end
		end else if (phase_q == PH_ACK_HI) begin
			if (!sda_in) begin
				n_tick = 8'd0;
				case (stage_q)
					STAGE_ADDR_W: begin
						n_stage = STAGE_REG;
						sb      = stage_byte(STAGE_REG, dev_addr_q, reg_addr_q, wr_data_q);
						n_shift = sb;
						n_bit   = 4'd0;
						n_phase = PH_SEND_LO;
						n_scl   = 1'b0;
						n_sda   = sb[7];
					end
					STAGE_REG: begin
						if (is_read_q) begin
							// repeated start before the read address
							n_stage = STAGE_ADDR_R;
							n_phase = PH_START_HI;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
						end else begin
							n_stage = STAGE_DATA;
							sb      = stage_byte(STAGE_DATA, dev_addr_q, reg_addr_q, wr_data_q);
							n_shift = sb;
							n_bit   = 4'd0;
							n_phase = PH_SEND_LO;
							n_scl   = 1'b0;
							n_sda   = sb[7];
						end
					end
					STAGE_DATA: begin
						n_phase = PH_STOP_LO;
						n_scl   = 1'b0;
						n_sda   = 1'b0;
					end
					default: begin
						n_shift = 8'd0;
						n_bit   = 4'd0;
						n_phase = PH_RECV_LO;
						n_scl   = 1'b0;
						n_sda   = 1'b1;
					end
				endcase
			end else if (tick_q >= ack_tmo_q) begin
				n_err   = 1'b1;
				n_phase = PH_STOP_LO;
				n_tick  = 8'd0;
				n_scl   = 1'b0;
				n_sda   = 1'b0;
			end else begin
				n_tick = tick_inc;
			end
		end else begin
			n_tick = tick_inc;
			if (tick_inc >= dur) begin
				n_tick = 8'd0;
				case (phase_q)
					PH_START_HI: begin
						n_phase = PH_START_LO;
						n_scl   = 1'b1;
						n_sda   = 1'b0;
					end
					PH_START_LO: begin
						sb      = stage_byte(stage_q, dev_addr_q, reg_addr_q, wr_data_q);
						n_shift = sb;
						n_bit   = 4'd0;
						n_phase = PH_SEND_LO;
						n_scl   = 1'b0;
						n_sda   = sb[7];
					end
					PH_SEND_LO: begin
						n_phase = PH_SEND_HI;
						n_scl   = 1'b1;
					end
					PH_SEND_HI: begin
						n_bit = bit_inc;
						if (bit_inc >= BITS_PER_BYTE) begin
							n_phase = PH_ACK_LO;
							n_scl   = 1'b0;
							n_sda   = 1'b1;
						end else begin
							n_shift = {shift_q[6:0], 1'b0};
							n_phase = PH_SEND_LO;
							n_scl   = 1'b0;
							n_sda   = shift_q[6];
						end
					end
					PH_ACK_LO: begin
						n_phase = PH_ACK_HI;
						n_scl   = 1'b1;
						n_sda   = 1'b1;
					end
					PH_RECV_LO: begin
						n_phase = PH_RECV_HI;
						n_scl   = 1'b1;
						n_sda   = 1'b1;
					end
					PH_RECV_HI: begin
						n_shift = recv_byte;
						n_bit   = bit_inc;
						if (bit_inc >= BITS_PER_BYTE) begin
							r_valid = 1'b1;
							r_data  = recv_byte;
							r_last  = (left_q <= 8'd1);
							n_phase = PH_MACK_LO;
							n_scl   = 1'b0;
							// ack every byte but the last
							n_sda   = (left_q <= 8'd1);
						end else begin
							n_phase = PH_RECV_LO;
							n_scl   = 1'b0;
							n_sda   = 1'b1;
						end
					end
					PH_MACK_LO: begin
						n_phase = PH_MACK_HI;
						n_scl   = 1'b1;
					end
					PH_MACK_HI: begin
						if (left_q <= 8'd1) begin
							n_phase = PH_STOP_LO;
							n_scl   = 1'b0;
							n_sda   = 1'b0;
						end else begin
							n_left  = left_q - 8'd1;
							n_shift = 8'd0;
							n_bit   = 4'd0;
							n_phase = PH_RECV_LO;
							n_scl   = 1'b0;
							n_sda   = 1'b1;
						end
					end
					PH_STOP_LO: begin
						n_phase = PH_STOP_HI;
						n_scl   = 1'b1;
						n_sda   = 1'b0;
					end
					PH_STOP_HI: begin
						n_phase = PH_STOP_REL;
						n_scl   = 1'b1;
						n_sda   = 1'b1;
					end
					PH_STOP_REL: begin
						r_done  = 1'b1;
						r_err   = err_q;
						n_phase = PH_IDLE;
						n_scl   = 1'b1;
						n_sda   = 1'b1;
					end
					default: begin
						n_phase = PH_IDLE;
						n_scl   = 1'b1;
						n_sda   = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			ack_tmo_q  <= ACK_TMO_RST;
			hold_q     <= HOLD_RST;
			half_q     <= HALF_BIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEV_ADDR: dev_addr_q <= cfg_data[6:0];
				REG_ACK_TMO:  ack_tmo_q  <= cfg_data;
				REG_HOLD:     hold_q     <= cfg_data;
				REG_HALF_BIT: half_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= 8'd0;
			shift_q    <= 8'd0;
			bit_q      <= 4'd0;
			left_q     <= 8'd0;
			is_read_q  <= 1'b0;
			reg_addr_q <= 8'd0;
			wr_data_q  <= 8'd0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			err_q      <= 1'b0;
			stage_q    <= STAGE_ADDR_W;
		end else if (accept) begin
			phase_q    <= n_phase;
			tick_q     <= n_tick;
			shift_q    <= n_shift;
			bit_q      <= n_bit;
			left_q     <= n_left;
			is_read_q  <= n_is_read;
			reg_addr_q <= n_reg_addr;
			wr_data_q  <= n_wr_data;
			scl_q      <= n_scl;
			sda_q      <= n_sda;
			err_q      <= n_err;
			stage_q    <= n_stage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with every accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			scl_out_q  <= n_scl;
			sda_out_q  <= n_sda;
			rd_out_q   <= r_data;
			rv_out_q   <= r_valid;
			lb_out_q   <= r_last;
			dn_out_q   <= r_done;
			ae_out_q   <= r_err;
			busy_out_q <= (n_phase != PH_IDLE);
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = scl_out_q;
	assign sda_level  = sda_out_q;
	assign read_data  = rd_out_q;
	assign read_valid = rv_out_q;
	assign last_byte  = lb_out_q;
	assign done_res   = dn_out_q;
	assign ack_error  = ae_out_q;
	assign busy_res   = busy_out_q;

`ifndef SYNTHESIS
	// an accepted beat always leaves a result waiting
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted beat produced no result");

	// a stalled result holds its payload
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(dn_out_q) && $stable(rd_out_q)
			&& $stable(busy_out_q))
		else $error("result changed while stalled");

	// done always returns the sequencer to idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dn_out_q |-> !busy_out_q)
		else $error("done while still busy");

	// error flag only travels with done
	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ae_out_q |-> dn_out_q)
		else $error("ack error without done");

	// received bytes only while the transfer is running
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rv_out_q |-> busy_out_q && !dn_out_q)
		else $error("read byte outside a transfer");
`endif

endmodule

@@ tb/sv/i2c_master_register_access_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_top_tb
// Drives timing ticks and register write/read commands into the I2C master,
// answers acknowledges and supplies read bits on sda_in, and checks every
// result beat against a cycle-free model of the bus sequencer or a scripted
// expected result. A short scripted run comes first. Randomised transfers follow
// under several timing settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top_tb
	import i2cm_pkg::*;
();

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int STUCK_LIMIT = 2000;
	localparam int SQUEEZE_CYCLES = 64;
	localparam int TOTAL_BEATS = 1550;
	localparam logic [7:0] LONG_READ = 8'd6;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic [7:0] read_count;
		logic       sda_in;
	} beat_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] rdata;
		logic       rvalid;
		logic       last;
		logic       done;
		logic       aerr;
		logic       busy;
	} bus_result_t;

	typedef enum logic [1:0] {ROW_BEAT, ROW_RUN_ACK, ROW_RUN_NACK} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		beat_t       b;
		bit          typed;
		bus_result_t want;
	} row_t;

	localparam bus_result_t IDLE_RES  = '{scl: 1'b1, sda: 1'b1, default: '0};
	localparam bus_result_t START_RES = '{scl: 1'b1, sda: 1'b1, busy: 1'b1, default: '0};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] action = ACT_TICK;
	logic [7:0] reg_address = '0;
	logic [7:0] write_data = '0;
	logic [7:0] read_count = '0;
	logic       sda_in = 1'b1;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl_level;
	logic       sda_level;
	logic [7:0] read_data;
	logic       read_valid;
	logic       last_byte;
	logic       done_res;
	logic       ack_error;
	logic       busy_res;

	i2c_master_register_access_top dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model of the sequencer: configuration and bus state
	logic [6:0]         m_dev;
	logic [7:0]         m_ack_tmo, m_hold, m_half;
	logic [PHASE_W-1:0] m_phase;
	logic [7:0]         m_ticks, m_shift, m_left, m_reg, m_data;
	logic [3:0]         m_bits;
	logic               m_read, m_scl, m_sda, m_err;
	logic [STAGE_W-1:0] m_stage;

	bus_result_t pending_drives [$];
	bus_result_t oldest;
	int unsigned beats_sent = 0;
	int unsigned mismatches = 0;
	int unsigned stuck = 0;
	int unsigned squeeze_left = 0;
	int unsigned ready_left = 0;
	bit          squeeze_req = 1'b0;
	bit          squeeze_once = 1'b0;
	bit          quiet = 1'b0;
	bit          calm = 1'b0;

	row_t script [13] = '{
		'{ROW_BEAT, '{ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, IDLE_RES},
		'{ROW_BEAT, '{ACT_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_RES},
		'{ROW_BEAT, '{ACT_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0}, 1'b1, START_RES},
		// commands while busy are ignored
		'{ROW_BEAT, '{ACT_READ, 8'h00, 8'hFF, 8'hFF, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, '{ACT_SPARE, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{ROW_RUN_ACK, '0, 1'b0, '0},
		// zero count reads a single byte
		'{ROW_BEAT, '{ACT_READ, 8'h00, 8'hFF, 8'h00, 1'b1}, 1'b1, START_RES},
		'{ROW_RUN_ACK, '0, 1'b0, '0},
		'{ROW_BEAT, '{ACT_READ, 8'hA5, 8'h00, 8'h02, 1'b0}, 1'b1, START_RES},
		'{ROW_RUN_ACK, '0, 1'b0, '0},
		// missing acknowledge aborts with a stop
		'{ROW_BEAT, '{ACT_WRITE, 8'h5A, 8'hFF, 8'h01, 1'b1}, 1'b1, START_RES},
		'{ROW_RUN_NACK, '0, 1'b0, '0},
		'{ROW_BEAT, '{ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, IDLE_RES}
	};

	function automatic void reset_model();
		m_dev = DEV_ADDR_RST;
		m_ack_tmo = ACK_TMO_RST;
		m_hold = HOLD_RST;
		m_half = HALF_BIT_RST;
		m_phase = PH_IDLE;
		m_ticks = '0;
		m_shift = '0;
		m_bits = '0;
		m_left = '0;
		m_read = 1'b0;
		m_reg = '0;
		m_data = '0;
		m_scl = 1'b1;
		m_sda = 1'b1;
		m_err = 1'b0;
		m_stage = STAGE_ADDR_W;
	endfunction

	function automatic logic [7:0] at_least_one(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function automatic void move_to(input logic [PHASE_W-1:0] p, input logic scl, input logic sda);
		m_phase = p;
		m_ticks = '0;
		m_scl = scl;
		m_sda = sda;
	endfunction

	function automatic void load_byte(input logic [7:0] v);
		m_shift = v;
		m_bits = '0;
		move_to(PH_SEND_LO, 1'b0, v[7]);
	endfunction

	function automatic void send_current();
		case (m_stage)
			STAGE_ADDR_W: load_byte({m_dev, 1'b0});
			STAGE_REG:    load_byte(m_reg);
			STAGE_DATA:   load_byte(m_data);
			default:      load_byte({m_dev, 1'b1});
		endcase
	endfunction

	function automatic void acked();
		case (m_stage)
			STAGE_ADDR_W: begin
				m_stage = STAGE_REG;
				send_current();
			end
			STAGE_REG: begin
				if (m_read) begin
					// repeated start before the read address
					m_stage = STAGE_ADDR_R;
					move_to(PH_START_HI, 1'b1, 1'b1);
				end else begin
					m_stage = STAGE_DATA;
					send_current();
				end
			end
			STAGE_DATA: move_to(PH_STOP_LO, 1'b0, 1'b0);
			default: begin
				m_shift = '0;
				m_bits = '0;
				move_to(PH_RECV_LO, 1'b0, 1'b1);
			end
		endcase
	endfunction

	// advance the model by one beat and return the drives and flags it shows
	function automatic bus_result_t bus_step(input beat_t b);
		bus_result_t r;
		logic [7:0]  span;
		r = '0;
		if (m_phase == PH_IDLE) begin
			if (b.action == ACT_WRITE || b.action == ACT_READ) begin
				m_read = (b.action == ACT_READ);
				m_reg = b.reg_address;
				m_data = b.write_data;
				m_left = (b.read_count == 8'd0) ? 8'd1 : b.read_count;
				m_err = 1'b0;
				m_stage = STAGE_ADDR_W;
				move_to(PH_START_HI, 1'b1, 1'b1);
			end
		end else if (m_phase == PH_ACK_HI) begin
			if (!b.sda_in) begin
				acked();
			end else if (m_ticks >= m_ack_tmo) begin
				m_err = 1'b1;
				move_to(PH_STOP_LO, 1'b0, 1'b0);
			end else begin
				m_ticks++;
			end
		end else begin
			span = (m_phase == PH_START_HI || m_phase == PH_START_LO ||
				m_phase == PH_STOP_HI || m_phase == PH_STOP_REL) ?
				at_least_one(m_hold) : at_least_one(m_half);
			m_ticks++;
			if (m_ticks >= span) begin
				case (m_phase)
					PH_START_HI: move_to(PH_START_LO, 1'b1, 1'b0);
					PH_START_LO: send_current();
					PH_SEND_LO:  move_to(PH_SEND_HI, 1'b1, m_sda);
					PH_SEND_HI: begin
						m_bits++;
						if (m_bits >= BITS_PER_BYTE) begin
							move_to(PH_ACK_LO, 1'b0, 1'b1);
						end else begin
							m_shift = m_shift << 1;
							move_to(PH_SEND_LO, 1'b0, m_shift[7]);
						end
					end
					PH_ACK_LO:   move_to(PH_ACK_HI, 1'b1, 1'b1);
					PH_RECV_LO:  move_to(PH_RECV_HI, 1'b1, 1'b1);
					PH_RECV_HI: begin
						m_shift = {m_shift[6:0], b.sda_in};
						m_bits++;
						if (m_bits >= BITS_PER_BYTE) begin
							r.rvalid = 1'b1;
							r.rdata = m_shift;
							r.last = (m_left <= 8'd1);
							move_to(PH_MACK_LO, 1'b0, r.last);
						end else begin
							move_to(PH_RECV_LO, 1'b0, 1'b1);
						end
					end
					PH_MACK_LO:  move_to(PH_MACK_HI, 1'b1, m_sda);
					PH_MACK_HI: begin
						if (m_left <= 8'd1) begin
							move_to(PH_STOP_LO, 1'b0, 1'b0);
						end else begin
							m_left--;
							m_shift = '0;
							m_bits = '0;
							move_to(PH_RECV_LO, 1'b0, 1'b1);
						end
					end
					PH_STOP_LO:  move_to(PH_STOP_HI, 1'b1, 1'b0);
					PH_STOP_HI:  move_to(PH_STOP_REL, 1'b1, 1'b1);
					PH_STOP_REL: begin
						r.done = 1'b1;
						r.aerr = m_err;
						move_to(PH_IDLE, 1'b1, 1'b1);
					end
					default: move_to(PH_IDLE, 1'b1, 1'b1);
				endcase
			end
		end
		r.scl = m_scl;
		r.sda = m_sda;
		r.busy = (m_phase != PH_IDLE);
		return r;
	endfunction

	task automatic report(input string what);
		mismatches++;
		$display("%0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// offer one beat, hold it until taken, then log what it should produce
	task automatic offer_beat(input beat_t b, input bit typed, input bus_result_t want);
		bus_result_t predicted;
		in_valid <= 1'b1;
		action <= b.action;
		reg_address <= b.reg_address;
		write_data <= b.write_data;
		read_count <= b.read_count;
		sda_in <= b.sda_in;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = bus_step(b);
		pending_drives.push_back(typed ? want : predicted);
		beats_sent++;
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// beat during a transfer: mostly ticks with stray commands; the slave side answers acks and returns read bits
	function automatic beat_t busy_tick(input bit nack);
		beat_t       b;
		int unsigned pick;
		b.reg_address = 8'($urandom_range(0, 255));
		b.write_data = 8'($urandom_range(0, 255));
		b.read_count = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 15);
		b.action = (pick == 0) ? ACT_WRITE : (pick == 1) ? ACT_READ :
			(pick == 2) ? ACT_SPARE : ACT_TICK;
		if (m_phase == PH_ACK_HI)
			b.sda_in = nack ? 1'b1 : ($urandom_range(0, 3) == 0);
		else
			b.sda_in = 1'($urandom_range(0, 1));
		return b;
	endfunction

	task automatic finish_transfer(input bit nack);
		while (m_phase != PH_IDLE)
			offer_beat(busy_tick(nack), 1'b0, '0);
	endtask

	task automatic run_transaction(input bit nack, input bit big_read);
		beat_t b;
		b.reg_address = 8'($urandom_range(0, 255));
		b.write_data = 8'($urandom_range(0, 255));
		b.read_count = 8'($urandom_range(0, 255));
		b.sda_in = 1'($urandom_range(0, 1));
		if (!big_read && $urandom_range(0, 5) == 0) begin
			b.action = $urandom_range(0, 1) ? ACT_SPARE : ACT_TICK;
			offer_beat(b, 1'b0, '0);
		end
		b.action = (big_read || $urandom_range(0, 1)) ? ACT_READ : ACT_WRITE;
		b.read_count = big_read ? LONG_READ : 8'($urandom_range(0, 4));
		offer_beat(b, 1'b0, '0);
		finish_transfer(nack);
	endtask

	// register writes only once the block has drained and gone idle
	task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_DEV_ADDR: m_dev = val[6:0];
			REG_ACK_TMO:  m_ack_tmo = val;
			REG_HOLD:     m_hold = val;
			default:      m_half = val;
		endcase
	endtask

	task automatic run_phase(input logic [6:0] dev, input logic [7:0] tmo, input logic [7:0] hold,
		input logic [7:0] half, input int txns, input bit nack_all, input bit big_read);
		set_reg(REG_DEV_ADDR, {1'b0, dev});
		set_reg(REG_ACK_TMO, tmo);
		set_reg(REG_HOLD, hold);
		set_reg(REG_HALF_BIT, half);
		// long receiver hold-off while beats keep coming
		if (squeeze_once) begin
			squeeze_once = 1'b0;
			squeeze_req = 1'b1;
		end
		calm = ($urandom_range(0, 3) == 0);
		repeat (txns)
			run_transaction(nack_all || (!big_read && $urandom_range(0, 9) == 0), big_read);
	endtask

	// receiver: random ready bursts, one long hold-off on request
	always @(posedge clk) begin
		if (squeeze_req) begin
			squeeze_req = 1'b0;
			squeeze_left = SQUEEZE_CYCLES;
		end
		if (squeeze_left != 0) begin
			out_ready <= 1'b0;
			squeeze_left--;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (ready_left != 0) begin
			ready_left--;
		end else begin
			ready_left = $urandom_range(1, 8);
			out_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				report("result beat with nothing pending");
			end else begin
				oldest = pending_drives.pop_front();
				check_field("scl_level", 8'(scl_level), 8'(oldest.scl));
				check_field("sda_level", 8'(sda_level), 8'(oldest.sda));
				check_field("read_data", read_data, oldest.rdata);
				check_field("read_valid", 8'(read_valid), 8'(oldest.rvalid));
				check_field("last_byte", 8'(last_byte), 8'(oldest.last));
				check_field("done_res", 8'(done_res), 8'(oldest.done));
				check_field("ack_error", 8'(ack_error), 8'(oldest.aerr));
				check_field("busy_res", 8'(busy_res), 8'(oldest.busy));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck = 0;
		else
			stuck++;
		if (stuck >= STUCK_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			case (script[i].kind)
				ROW_BEAT:    offer_beat(script[i].b, script[i].typed, script[i].want);
				ROW_RUN_ACK: finish_transfer(1'b0);
				default:     finish_transfer(1'b1);
			endcase
		end

		squeeze_once = 1'b1;
		// zero timings count as one tick, zero timeout fails on the first high sample
		run_phase(7'd0, 8'd0, 8'd0, 8'd0, 3, 1'b0, 1'b0);
		// longest acknowledge timeout, aborted at the first acknowledge
		run_phase(7'd127, 8'd255, 8'd1, 8'd1, 1, 1'b1, 1'b0);
		// multi-byte read at the fastest bit rate
		run_phase(7'($urandom_range(0, 127)), 8'd1, 8'd1, 8'd1, 1, 1'b0, 1'b1);

		while (beats_sent < TOTAL_BEATS) begin
			if (beats_sent > TOTAL_BEATS - 150)
				quiet = 1'b1;
			run_phase(7'($urandom_range(0, 127)), 8'($urandom_range(1, 6)),
				8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)), 1, 1'b0, 1'b0);
		end

		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
